FILE: rtl/longest_increasing_subsequence_length_assert.svh
// Assertion macros used by the checker file.
`ifndef LONGEST_INCREASING_SUBSEQUENCE_LENGTH_ASSERT_SVH
`define LONGEST_INCREASING_SUBSEQUENCE_LENGTH_ASSERT_SVH

// Same-cycle implication.
`define LIS_ASSERT_NOW(lbl, ck, rstn, ante, cons) \
lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
	else $error("lis check failed");

// Next-cycle implication.
`define LIS_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
	else $error("lis check failed");

`endif

FILE: rtl/lis_pkg.sv
`default_nettype none
package lis_pkg;
	localparam int MAX_LEN    = 1024;
	localparam int VALUE_BITS = 32;
	localparam int LEN_BITS   = $clog2(MAX_LEN + 1);
	localparam int ADDR_BITS  = $clog2(MAX_LEN);

	typedef logic [VALUE_BITS-1:0] key_t;
	typedef logic [LEN_BITS-1:0]   len_t;
endpackage
`default_nettype wire

FILE: rtl/longest_increasing_subsequence_length.sv
// Longest strictly increasing subsequence length, one sample per word.
// Input channel: sample_value (signed), end_of_sequence, with
// sample_valid / sample_ready. Output channel: run_length,
// table_overflow, final_result, with result_valid / result_ready.
// Each word yields exactly one result word.
// A word is placed by binary search over a 1024-entry tail memory with one
// registered read port; one comparator probes one entry per cycle.
// After acceptance the word takes k probes and then loads its result, where k
// is at most ceil(log2(L + 1)) for run length L (k <= 11).
// The block takes the next word in the cycle after the result is loaded.
// A finished result waits in the output register while the next word is
// accepted and searched; if the receiver still stalls when that word is
// done, the block holds until the earlier result is taken.
// Reset clears the run length, the sticky overflow flag and the result
// valid flag; the tail memory is not cleared and needs no sweep.
// An end_of_sequence word reports its length and then clears the run.
`default_nettype none
module longest_increasing_subsequence_length (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 sample_valid,
	output logic                                      sample_ready,
	input  wire logic signed [31:0]                   sample_value,
	input  wire logic                                 end_of_sequence,
	output logic                                      result_valid,
	input  wire logic                                 result_ready,
	output logic [10:0]                               run_length,
	output logic                                      table_overflow,
	output logic                                      final_result
);
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_WRITE  = 2'd2;

	localparam lis_pkg::key_t SIGN_FLIP = lis_pkg::key_t'(1) << (lis_pkg::VALUE_BITS - 1);
	localparam lis_pkg::len_t LEN_FULL  = lis_pkg::len_t'(lis_pkg::MAX_LEN);

	logic [1:0]    state_q;
	lis_pkg::key_t key_q;
	logic          last_q;
	lis_pkg::len_t lo_q, hi_q, mid_q, len_q;
	logic          pend_q;
	logic          ovf_q;
	lis_pkg::key_t rd_q;
	logic          res_valid_q;
	lis_pkg::len_t res_len_q;
	logic          res_ovf_q;
	logic          res_last_q;

	lis_pkg::key_t mem [lis_pkg::MAX_LEN];

	lis_pkg::len_t lo_n, hi_n, mid_n;
	logic [lis_pkg::LEN_BITS:0] sum_n;
	logic          probe_more;
	logic          rd_en;
	logic          load_out;
	logic          wr_en;
	lis_pkg::len_t wr_pos;
	lis_pkg::len_t len_new;
	logic          ovf_new;

	// Narrow the window by the probe that returned this cycle, then pick the next midpoint.
	always_comb begin
		lo_n = lo_q;
		hi_n = hi_q;
		if (pend_q) begin
			if (rd_q < key_q) begin
				lo_n = mid_q + lis_pkg::len_t'(1);
			end else begin
				hi_n = mid_q;
			end
		end
		sum_n      = {1'b0, lo_n} + {1'b0, hi_n};
		mid_n      = sum_n[lis_pkg::LEN_BITS:1];
		probe_more = (lo_n < hi_n);
		rd_en      = (state_q == ST_SEARCH) && probe_more;
	end

	always_comb begin
		load_out = (state_q == ST_WRITE) && (!res_valid_q || result_ready);
		wr_en    = 1'b0;
		wr_pos   = lo_q;
		len_new  = len_q;
		ovf_new  = ovf_q;
		if (lo_q < len_q) begin
			wr_en = load_out;
		end else if (len_q != LEN_FULL) begin
			wr_en   = load_out;
			wr_pos  = len_q;
			len_new = len_q + lis_pkg::len_t'(1);
		end else begin
			ovf_new = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[mid_n[lis_pkg::ADDR_BITS-1:0]];
		end
		if (wr_en) begin
			mem[wr_pos[lis_pkg::ADDR_BITS-1:0]] <= key_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && sample_valid) begin
			key_q  <= lis_pkg::key_t'(sample_value) ^ SIGN_FLIP;
			last_q <= end_of_sequence;
		end
		if (rd_en) begin
			mid_q <= mid_n;
		end
		if (load_out) begin
			res_len_q  <= len_new;
			res_ovf_q  <= ovf_new;
			res_last_q <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lo_q        <= '0;
			hi_q        <= '0;
			pend_q      <= 1'b0;
			len_q       <= '0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (sample_valid) begin
						lo_q    <= '0;
						hi_q    <= len_q;
						pend_q  <= 1'b0;
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					lo_q   <= lo_n;
					hi_q   <= hi_n;
					pend_q <= probe_more;
					if (!probe_more) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					// Hold until the previous result has left the output register.
					if (load_out) begin
						ovf_q       <= ovf_new;
						len_q       <= last_q ? '0 : len_new;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign sample_ready   = (state_q == ST_IDLE);
	assign result_valid   = res_valid_q;
	assign run_length     = res_len_q;
	assign table_overflow = res_ovf_q;
	assign final_result   = res_last_q;
endmodule
`default_nettype wire

FILE: rtl/lis_checker.sv
`default_nettype none
`include "longest_increasing_subsequence_length_assert.svh"
module lis_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               sample_valid,
	input wire logic               sample_ready,
	input wire logic               result_valid,
	input wire logic               result_ready,
	input wire logic [10:0]        run_length,
	input wire logic               table_overflow,
	input wire logic               final_result
);
	`LIS_ASSERT_NOW(a_len_bound, clk, arst_n, result_valid, run_length <= 11'(lis_pkg::MAX_LEN))
	`LIS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, sample_valid && sample_ready, !sample_ready)
	`LIS_ASSERT_NEXT(a_ovf_sticky, clk, arst_n, result_valid && table_overflow, table_overflow)
	`LIS_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(run_length) && $stable(final_result))
endmodule

bind longest_increasing_subsequence_length lis_checker u_lis_checker (.*);
`default_nettype wire
